### hw/rtl/scsd_pkg.sv
`timescale 1ns / 1ps
// Package for the sprite command stream decoder: item types, register
// indexes and command opcodes. No dependencies.
package scsd_pkg;

  localparam int unsigned CfgIndexWidth = 8;

  localparam logic [CfgIndexWidth-1:0] REG_IMAGE_WIDTH  = 8'd0;
  localparam logic [CfgIndexWidth-1:0] REG_IMAGE_HEIGHT = 8'd1;

  localparam logic [1:0] OP_SET_COL = 2'd0;
  localparam logic [1:0] OP_RUN     = 2'd1;
  localparam logic [1:0] OP_SET_ROW = 2'd2;
  localparam logic [1:0] OP_END     = 2'd3;

  typedef struct packed {
    logic [7:0] stream_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [15:0] pixel_col;
    logic [13:0] pixel_row;
    logic [7:0]  color_index;
    logic        is_end_marker;
  } out_item_t;

  typedef struct packed {
    logic [CfgIndexWidth-1:0] index;
    logic [15:0]              data;
  } cfg_write_t;

endpackage

### hw/rtl/scsd_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the decoder: byte input, result output
// and register writes. Depends on scsd_pkg.
interface scsd_in_if;
  logic              valid;
  logic              ready;
  scsd_pkg::in_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface scsd_out_if;
  logic               valid;
  logic               ready;
  scsd_pkg::out_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface scsd_cfg_if;
  logic                valid;
  logic                ready;
  scsd_pkg::cfg_write_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

### hw/rtl/sprite_command_stream_decoder_core.sv
`timescale 1ns / 1ps
// Sprite command stream decoder, top level.
// Depends on scsd_pkg and the channel interfaces in scsd_if.sv.

// Takes one stream byte per cycle and decodes it in a single pass into at
// most one result (a pixel or an end marker), which lands in a two-entry
// output buffer. A byte is accepted in every cycle as long as the second
// buffer entry is free, so the rate is one byte per clock; stream.ready drops
// only when two results are waiting on a stalled output. Each result is
// registered in the output buffer before it is offered. With image_width or
// image_height zero no results are made. Register writes are always ready
// and must be issued while the decoder is idle.
module sprite_command_stream_decoder_core (
  input  logic            clk,
  input  logic            rst,
  scsd_in_if.sink         stream,
  scsd_out_if.source      pixel,
  scsd_cfg_if.sink        cfg
);

  localparam logic [1:0] PH_LOW  = 2'd0;
  localparam logic [1:0] PH_HIGH = 2'd1;
  localparam logic [1:0] PH_RUN  = 2'd2;

  logic [15:0] image_width;
  logic [15:0] image_height;

  logic [1:0]  parse_phase, parse_phase_next;
  logic [7:0]  low_byte_hold, low_byte_hold_next;
  logic [15:0] cur_col, cur_col_next;
  logic [13:0] cur_row, cur_row_next;
  logic [13:0] run_remaining, run_remaining_next;

  scsd_pkg::out_item_t result;
  logic                has_result;

  scsd_pkg::out_item_t head, tail;
  logic                head_valid, tail_valid;

  logic        accept, push, pop, active;
  logic [15:0] word;
  logic [1:0]  op;
  logic [13:0] arg;
  logic [13:0] run_dec;

  assign cfg.ready    = 1'b1;
  assign stream.ready = !tail_valid;
  assign accept       = stream.valid && stream.ready;
  assign pop          = head_valid && pixel.ready;
  assign push         = accept && has_result;

  assign pixel.valid   = head_valid;
  assign pixel.payload = head;

  assign active  = (image_width != 16'd0) && (image_height != 16'd0);
  assign word    = {stream.payload.stream_byte, low_byte_hold};
  assign op      = word[1:0];
  assign arg     = word[15:2];
  assign run_dec = run_remaining - 14'd1;

  always_comb begin
    parse_phase_next   = parse_phase;
    low_byte_hold_next = low_byte_hold;
    cur_col_next       = cur_col;
    cur_row_next       = cur_row;
    run_remaining_next = run_remaining;
    result             = '0;
    has_result         = 1'b0;
    if (active) begin
      case (parse_phase)
        PH_HIGH: begin
          parse_phase_next = PH_LOW;
          case (op)
            scsd_pkg::OP_SET_COL: cur_col_next = {2'b00, arg};
            scsd_pkg::OP_SET_ROW: cur_row_next = arg;
            scsd_pkg::OP_RUN: begin
              if (arg != 14'd0) begin
                run_remaining_next = arg;
                parse_phase_next   = PH_RUN;
              end else begin
                cur_col_next = 16'd0;
              end
            end
            default: begin
              result.is_end_marker = 1'b1;
              has_result           = 1'b1;
            end
          endcase
        end
        PH_RUN: begin
          result.pixel_col   = cur_col;
          result.pixel_row   = cur_row;
          result.color_index = stream.payload.stream_byte;
          has_result         = 1'b1;
          cur_col_next       = cur_col + 16'd1;
          run_remaining_next = run_dec;
          if (run_dec == 14'd0) begin
            cur_col_next     = 16'd0;
            parse_phase_next = PH_LOW;
          end
        end
        default: begin
          low_byte_hold_next = stream.payload.stream_byte;
          parse_phase_next   = PH_HIGH;
        end
      endcase
    end
    if (stream.payload.last_byte) begin
      parse_phase_next   = PH_LOW;
      low_byte_hold_next = 8'd0;
      cur_col_next       = 16'd0;
      cur_row_next       = 14'd0;
      run_remaining_next = 14'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= 16'd0;
      image_height <= 16'd0;
    end else if (cfg.valid) begin
      if (cfg.payload.index == scsd_pkg::REG_IMAGE_WIDTH) begin
        image_width <= cfg.payload.data;
      end else if (cfg.payload.index == scsd_pkg::REG_IMAGE_HEIGHT) begin
        image_height <= cfg.payload.data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      parse_phase   <= PH_LOW;
      low_byte_hold <= 8'd0;
      cur_col       <= 16'd0;
      cur_row       <= 14'd0;
      run_remaining <= 14'd0;
    end else if (accept) begin
      parse_phase   <= parse_phase_next;
      low_byte_hold <= low_byte_hold_next;
      cur_col       <= cur_col_next;
      cur_row       <= cur_row_next;
      run_remaining <= run_remaining_next;
    end
  end

  // two-entry output buffer: head drives the port, tail catches a result
  // made while head is stalled
  always_ff @(posedge clk) begin
    if (rst) begin
      head_valid <= 1'b0;
      tail_valid <= 1'b0;
    end else if (pop && push) begin
      if (tail_valid) begin
        head <= tail;
        tail <= result;
      end else begin
        head <= result;
      end
    end else if (pop) begin
      head       <= tail;
      head_valid <= tail_valid;
      tail_valid <= 1'b0;
    end else if (push) begin
      if (!head_valid) begin
        head       <= result;
        head_valid <= 1'b1;
      end else begin
        tail       <= result;
        tail_valid <= 1'b1;
      end
    end
  end

endmodule
